/* hw/rtl/elfchk_pkg.sv */
`default_nettype none
package elfchk_pkg;

	localparam logic [31:0] ELF_MAGIC      = 32'h464C_457F;
	localparam logic [7:0]  CLASS_64       = 8'd2;
	localparam logic [7:0]  ORDER_LE       = 8'd1;
	localparam logic [15:0] PHDR_BYTES     = 16'd56;
	localparam logic [63:0] HEADER_BYTES   = 64'd64;
	localparam logic [31:0] SEG_LOAD       = 32'd1;
	localparam logic        MODE_HEADER    = 1'b0;
	localparam logic [63:0] MIN_LOAD_RESET = 64'h0000_0000_0040_0000;
	localparam logic [15:0] MACHINE_RESET  = 16'd62;
	localparam logic [63:0] SPAN_LOW_RESET = 64'hFFFF_FFFF_FFFF_FFFF;

	localparam logic REG_MIN_LOAD = 1'b0;
	localparam logic REG_MACHINE  = 1'b1;

	localparam logic [1:0] OP_HDR_FAIL = 2'd0;
	localparam logic [1:0] OP_HDR_OPEN = 2'd1;
	localparam logic [1:0] OP_HDR_ZERO = 2'd2;
	localparam logic [1:0] OP_SEG      = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic        last;
		logic        load;
		logic        bad;
		logic        wrap;
		logic [63:0] addr;
		logic [63:0] top;
	} op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage
`default_nettype wire

/* hw/rtl/elfchk_front.sv */
`default_nettype none
module elfchk_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire                   mode,
	input  wire  [31:0]           magic,
	input  wire  [7:0]            elf_class,
	input  wire  [7:0]            byte_order,
	input  wire  [15:0]           machine,
	input  wire  [15:0]           entry_size,
	input  wire  [15:0]           entry_count,
	input  wire  [31:0]           seg_type,
	input  wire  [63:0]           offset,
	input  wire  [63:0]           address,
	input  wire  [63:0]           length,
	input  wire  [63:0]           mem_size,
	input  wire  [63:0]           min_load_address,
	input  wire  [15:0]           expected_machine,
	input  elfchk_pkg::qstat_t    qstat,
	output logic                  push,
	output elfchk_pkg::op_t       op
);
	import elfchk_pkg::*;

	logic        in_image_q;
	logic [15:0] remaining_q;
	logic [63:0] size_held_q;

	logic        accept;
	logic        is_header;
	logic [21:0] table_bytes;
	logic        hdr_ok;
	logic        seg_bad;
	logic [63:0] top;

	assign in_stall    = qstat.full;
	assign accept      = in_valid && !qstat.full;
	assign is_header   = (mode == MODE_HEADER);
	assign table_bytes = 22'(entry_count) * 22'(PHDR_BYTES);
	assign top         = address + mem_size;

	assign hdr_ok = (length >= HEADER_BYTES) && (magic == ELF_MAGIC) &&
		(elf_class == CLASS_64) && (byte_order == ORDER_LE) &&
		(machine == expected_machine) && (entry_size == PHDR_BYTES) &&
		(offset <= length) && (64'(table_bytes) <= (length - offset));

	assign seg_bad = (length > mem_size) || (offset > size_held_q) ||
		(length > (size_held_q - offset)) || (address < min_load_address);

	assign push = accept && (is_header || in_image_q);

	always_comb begin
		op.addr = address;
		op.top  = top;
		op.load = (seg_type == SEG_LOAD);
		op.bad  = seg_bad;
		op.wrap = (top < address);
		op.last = (remaining_q == 16'd1);
		if (is_header) begin
			if (!hdr_ok) begin
				op.kind = OP_HDR_FAIL;
			end else if (entry_count == 16'd0) begin
				op.kind = OP_HDR_ZERO;
			end else begin
				op.kind = OP_HDR_OPEN;
			end
		end else begin
			op.kind = OP_SEG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_image_q  <= 1'b0;
			remaining_q <= '0;
			size_held_q <= '0;
		end else if (accept) begin
			if (is_header) begin
				if (hdr_ok) begin
					in_image_q  <= (entry_count != 16'd0);
					remaining_q <= entry_count;
					size_held_q <= length;
				end else begin
					in_image_q  <= 1'b0;
					remaining_q <= '0;
					size_held_q <= '0;
				end
			end else if (in_image_q) begin
				remaining_q <= remaining_q - 16'd1;
				if (remaining_q == 16'd1) begin
					in_image_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/elfchk_queue.sv */
`default_nettype none
module elfchk_queue #(
	parameter int DEPTH = 4
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  elfchk_pkg::op_t       op_in,
	input  wire                   pop,
	output elfchk_pkg::op_t       op_out,
	output elfchk_pkg::qstat_t    qstat
);
	import elfchk_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign op_out      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/elfchk_back.sv */
`default_nettype none
module elfchk_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  elfchk_pkg::op_t       op,
	input  elfchk_pkg::qstat_t    qstat,
	output logic                  pop,
	output logic                  out_valid,
	input  wire                   out_stall,
	output logic                  accepted,
	output logic [63:0]           entry_out,
	output logic [63:0]           span_start,
	output logic [63:0]           span_end
);
	import elfchk_pkg::*;

	logic        failed_q;
	logic [63:0] span_low_q;
	logic [63:0] span_high_q;
	logic [63:0] entry_q;
	logic        out_valid_q;
	logic        accepted_q;
	logic [63:0] entry_out_q;
	logic [63:0] span_start_q;
	logic [63:0] span_end_q;

	logic        emits;
	logic        nx_failed;
	logic [63:0] nx_low;
	logic [63:0] nx_high;
	logic        verdict;

	assign emits = (op.kind != OP_HDR_OPEN) && ((op.kind != OP_SEG) || op.last);
	assign pop   = !qstat.empty && (!emits || !out_valid_q || !out_stall);

	always_comb begin
		nx_failed = failed_q;
		nx_low    = span_low_q;
		nx_high   = span_high_q;
		if (op.load && !failed_q) begin
			if (op.bad) begin
				nx_failed = 1'b1;
			end else begin
				if (op.addr < span_low_q) begin
					nx_low = op.addr;
				end
				if (op.wrap) begin
					nx_failed = 1'b1;
				end else if (op.top > span_high_q) begin
					nx_high = op.top;
				end
			end
		end
	end

	assign verdict = !nx_failed && (entry_q >= nx_low) && (entry_q < nx_high);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q    <= 1'b0;
			span_low_q  <= SPAN_LOW_RESET;
			span_high_q <= '0;
			entry_q     <= '0;
		end else if (pop) begin
			case (op.kind)
				OP_SEG: begin
					failed_q    <= nx_failed;
					span_low_q  <= nx_low;
					span_high_q <= nx_high;
				end
				OP_HDR_OPEN: begin
					failed_q    <= 1'b0;
					span_low_q  <= SPAN_LOW_RESET;
					span_high_q <= '0;
					entry_q     <= op.addr;
				end
				default: begin
					failed_q    <= 1'b0;
					span_low_q  <= SPAN_LOW_RESET;
					span_high_q <= '0;
					entry_q     <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emits) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emits) begin
			if (op.kind == OP_SEG && verdict) begin
				accepted_q   <= 1'b1;
				entry_out_q  <= entry_q;
				span_start_q <= nx_low;
				span_end_q   <= nx_high;
			end else begin
				accepted_q   <= 1'b0;
				entry_out_q  <= '0;
				span_start_q <= '0;
				span_end_q   <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign accepted   = accepted_q;
	assign entry_out  = entry_out_q;
	assign span_start = span_start_q;
	assign span_end   = span_end_q;

endmodule
`default_nettype wire

/* hw/rtl/elf64_load_image_checker.sv */
// A transaction is written into the queue when accepted; the back end pops it and
// registers out_valid if it ends an image; queued transactions ahead of it pop first.
// Throughput: one item per cycle when unstalled; front classifies, back updates span.
// Queue of QUEUE_DEPTH classified transactions decouples input stall from output stall.
// Reset: asynchronous, active low; clears the queue, image tracking and output valid,
// and returns min_load_address to 0x400000 and expected_machine to 62.
`default_nettype none
module elf64_load_image_checker #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         mode,
	input  wire  [31:0] magic,
	input  wire  [7:0]  elf_class,
	input  wire  [7:0]  byte_order,
	input  wire  [15:0] machine,
	input  wire  [15:0] entry_size,
	input  wire  [15:0] entry_count,
	input  wire  [31:0] seg_type,
	input  wire  [63:0] offset,
	input  wire  [63:0] address,
	input  wire  [63:0] length,
	input  wire  [63:0] mem_size,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        accepted,
	output logic [63:0] entry_out,
	output logic [63:0] span_start,
	output logic [63:0] span_end
);
	import elfchk_pkg::*;

	logic [63:0] min_load_q;
	logic [15:0] machine_q;
	logic        cfg_write;

	qstat_t      qstat;
	op_t         push_op;
	op_t         head_op;
	logic        push;
	logic        pop;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_load_q <= MIN_LOAD_RESET;
			machine_q  <= MACHINE_RESET;
		end else if (cfg_write) begin
			case (paddr[3])
				REG_MIN_LOAD: min_load_q <= pwdata;
				REG_MACHINE:  machine_q  <= pwdata[15:0];
				default:      min_load_q <= min_load_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			REG_MIN_LOAD: prdata = min_load_q;
			REG_MACHINE:  prdata = 64'(machine_q);
			default:      prdata = '0;
		endcase
	end

	elfchk_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.mode             (mode),
		.magic            (magic),
		.elf_class        (elf_class),
		.byte_order       (byte_order),
		.machine          (machine),
		.entry_size       (entry_size),
		.entry_count      (entry_count),
		.seg_type         (seg_type),
		.offset           (offset),
		.address          (address),
		.length           (length),
		.mem_size         (mem_size),
		.min_load_address (min_load_q),
		.expected_machine (machine_q),
		.qstat            (qstat),
		.push             (push),
		.op               (push_op)
	);

	elfchk_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.op_in  (push_op),
		.pop    (pop),
		.op_out (head_op),
		.qstat  (qstat)
	);

	elfchk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (head_op),
		.qstat      (qstat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.accepted   (accepted),
		.entry_out  (entry_out),
		.span_start (span_start),
		.span_end   (span_end)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	a_reject_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !accepted) |->
			(entry_out == 64'd0 && span_start == 64'd0 && span_end == 64'd0))
		else $error("rejected transaction carries nonzero fields");

	a_accept_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && accepted) |-> (span_start <= entry_out && entry_out < span_end))
		else $error("accepted entry point outside image span");

endmodule
`default_nettype wire
